// File: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the postfix expression evaluator: stack
// sizing, character codes, status codes, sequencer states and the divider
// request bundle.
// ----------------------------------------------------------------------------
package rpn_pkg;

   // Stack sizing.
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);

   // Word and field widths.
   localparam int WORD_W   = 32;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 3;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEPTH     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 3'd5;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_PEND,
      S_MAIN,
      S_EOL_FIN,
      S_OP_RD,
      S_OP_RD2,
      S_OP_EXEC,
      S_DIV_WAIT,
      S_END,
      S_REPORT,
      S_OUT
   } state_type;

   // Request to the divider.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

endpackage

// File: sv/rpn_if.sv
// ----------------------------------------------------------------------------
// rpn_req_if / rpn_rsp_if
// Valid/ready channels for the character items and the result items.
// ----------------------------------------------------------------------------
interface rpn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_line;

   modport source (output valid, output character, output end_of_line, input ready);
   modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

interface rpn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [2:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// File: sv/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Signed 32-bit divider, truncating toward zero. Restoring division on the
// magnitudes, one quotient bit per cycle, sign applied at the end.
// ----------------------------------------------------------------------------
module rpn_div (
   input  logic                       clock,
   input  logic                       reset,
   input  rpn_pkg::div_req_type       req,
   output logic                       done,
   output logic [rpn_pkg::WORD_W-1:0] quotient
);
   import rpn_pkg::*;

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic [WORD_W-1:0] rem_ff,  rem_in;
   logic [WORD_W-1:0] quo_ff,  quo_in;
   logic [WORD_W-1:0] dvs_ff,  dvs_in;
   logic              neg_ff,  neg_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   trial;

   // One restoring step per cycle.
   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend[WORD_W-1] ? -req.dividend : req.dividend;
         dvs_in  = req.divisor[WORD_W-1] ? -req.divisor : req.divisor;
         neg_in  = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
         cnt_in  = CNT_W'(WORD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;
endmodule

// File: sv/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression fed one ASCII character per item on an
// operand stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one character per item plus end_of_line on the last one.
//   rsp_ch carries one result item (value, status) per expression, after the
//   item flagged end_of_line; no other item produces a result.
//   One item is taken at a time. A digit or separator steps through S_PEND,
//   S_MAIN and S_EOL_FIN; + - * add two stack reads through the registered
//   RAM read port and a write back; / waits for the 32-step divider loop.
//   A line end adds S_REPORT and S_OUT to read stack entry 0 and load the result.
//   Reset clears the stack pointer, number builder and error state; the
//   stack RAM itself is not cleared, since only entries below the stack
//   pointer are read. The result sits in an output register; while it is
//   not taken, the block keeps accepting characters and only holds when a
//   second result is ready to be loaded.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
   input  logic      clock,
   input  logic      reset,
   rpn_req_if.sink   req_ch,
   rpn_rsp_if.source rsp_ch
);
   import rpn_pkg::*;

   state_type          state_ff, state_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic               in_num_ff, in_num_in;
   logic               neg_ff, neg_in;
   logic               pend_ff, pend_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [CHAR_W-1:0]  chr_ff, chr_in;
   logic               eol_ff, eol_in;
   logic [CHAR_W-1:0]  op_ff, op_in;
   logic               ret_main_ff, ret_main_in;
   logic [WORD_W-1:0]  b_ff, b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [WORD_W-1:0]  rd_data;
   div_req_type        div_req;
   logic               div_done;
   logic [WORD_W-1:0]  div_q;

   logic               accept;
   logic               is_digit, is_minus, is_arith, is_sep;
   logic               full, push_fail, b_zero, out_free;
   logic [WORD_W-1:0]  num_val, acc_base, arith_res;
   logic [ADDR_W-1:0]  top_addr, second_addr;
   logic [STATUS_W-1:0] final_status;

   rpn_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_W)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   // Character classes and shared decodes.
   always_comb begin
      accept      = req_ch.valid && req_ch.ready;
      is_digit    = (chr_ff >= CH_ZERO) && (chr_ff <= CH_NINE);
      is_minus    = (chr_ff == CH_MINUS);
      is_arith    = (chr_ff == CH_PLUS) || (chr_ff == CH_STAR) || (chr_ff == CH_SLASH);
      is_sep      = (chr_ff == CH_SPACE) || (chr_ff == CH_LF) || (chr_ff == CH_CR);
      full        = (sp_ff == SP_W'(STACK_DEPTH));
      push_fail   = in_num_ff && full;
      num_val     = neg_ff ? -acc_ff : acc_ff;
      acc_base    = in_num_ff ? acc_ff : '0;
      top_addr    = ADDR_W'(sp_ff - SP_W'(1));
      second_addr = ADDR_W'(sp_ff - SP_W'(2));
      b_zero      = (b_ff == '0);
      out_free    = !rsp_valid_ff || rsp_ch.ready;
      if (err_ff != ST_OK) begin
         final_status = err_ff;
      end else if (sp_ff != SP_W'(1)) begin
         final_status = ST_DEPTH;
      end else begin
         final_status = ST_OK;
      end
      case (op_ff)
         CH_PLUS:  arith_res = rd_data + b_ff;
         CH_MINUS: arith_res = rd_data - b_ff;
         default:  arith_res = rd_data * b_ff;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (err_ff != ST_OK) ? S_END : S_PEND;
            end
         end
         S_PEND: begin
            state_in = (pend_ff && !is_digit) ? S_OP_RD : S_MAIN;
         end
         S_MAIN: begin
            if (is_digit || is_sep) begin
               state_in = S_EOL_FIN;
            end else if (is_minus) begin
               if (push_fail) begin
                  state_in = S_END;
               end else begin
                  state_in = eol_ff ? S_OP_RD : S_EOL_FIN;
               end
            end else if (is_arith) begin
               state_in = push_fail ? S_END : S_OP_RD;
            end else begin
               state_in = S_END;
            end
         end
         S_EOL_FIN: state_in = S_END;
         S_OP_RD: begin
            state_in = (sp_ff < SP_W'(2)) ? S_END : S_OP_RD2;
         end
         S_OP_RD2: state_in = S_OP_EXEC;
         S_OP_EXEC: begin
            if (op_ff == CH_SLASH) begin
               state_in = b_zero ? S_END : S_DIV_WAIT;
            end else begin
               state_in = ret_main_ff ? S_MAIN : S_EOL_FIN;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = ret_main_ff ? S_MAIN : S_EOL_FIN;
            end
         end
         S_END:    state_in = eol_ff ? S_REPORT : S_IDLE;
         S_REPORT: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and stack access.
   always_comb begin
      sp_in         = sp_ff;
      acc_in        = acc_ff;
      in_num_in     = in_num_ff;
      neg_in        = neg_ff;
      pend_in       = pend_ff;
      err_in        = err_ff;
      chr_in        = chr_ff;
      eol_in        = eol_ff;
      op_in         = op_ff;
      ret_main_in   = ret_main_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = sp_ff[ADDR_W-1:0];
      wr_data       = num_val;
      rd_addr       = '0;
      div_req       = '{start: 1'b0, dividend: rd_data, divisor: b_ff};
      req_ch.ready  = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               chr_in = req_ch.character;
               eol_in = req_ch.end_of_line;
            end
         end
         S_PEND: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (is_digit) begin
                  in_num_in = 1'b1;
                  neg_in    = 1'b1;
                  acc_in    = '0;
               end else begin
                  op_in       = CH_MINUS;
                  ret_main_in = 1'b1;
               end
            end
         end
         S_MAIN, S_EOL_FIN: begin
            if (state_ff == S_MAIN && is_digit) begin
               if (!in_num_ff) begin
                  neg_in = 1'b0;
               end
               in_num_in = 1'b1;
               acc_in    = (acc_base << 3) + (acc_base << 1)
                         + {{(WORD_W-4){1'b0}}, chr_ff[3:0]};
            end else if (state_ff == S_MAIN && !is_minus && !is_arith && !is_sep) begin
               if (err_ff == ST_OK) begin
                  err_in = ST_BAD_CHAR;
               end
            end else if ((state_ff == S_MAIN) || (eol_ff && err_ff == ST_OK)) begin
               // Finish the number being built.
               if (in_num_ff) begin
                  in_num_in = 1'b0;
                  neg_in    = 1'b0;
                  acc_in    = '0;
                  if (full) begin
                     if (err_ff == ST_OK) begin
                        err_in = ST_OVERFLOW;
                     end
                  end else begin
                     wr_en = 1'b1;
                     sp_in = sp_ff + SP_W'(1);
                  end
               end
               if (state_ff == S_MAIN && !push_fail) begin
                  if (is_minus && !eol_ff) begin
                     pend_in = 1'b1;
                  end else if (is_minus || is_arith) begin
                     op_in       = chr_ff;
                     ret_main_in = 1'b0;
                  end
               end
            end
         end
         S_OP_RD: begin
            rd_addr = top_addr;
            if (sp_ff < SP_W'(2) && err_ff == ST_OK) begin
               err_in = ST_UNDERFLOW;
            end
         end
         S_OP_RD2: begin
            rd_addr = second_addr;
            b_in    = rd_data;
         end
         S_OP_EXEC: begin
            if (op_ff == CH_SLASH) begin
               if (b_zero) begin
                  if (err_ff == ST_OK) begin
                     err_in = ST_DIV_ZERO;
                  end
               end else begin
                  div_req.start = 1'b1;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = second_addr;
               wr_data = arith_res;
               sp_in   = sp_ff - SP_W'(1);
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               wr_en   = 1'b1;
               wr_addr = second_addr;
               wr_data = div_q;
               sp_in   = sp_ff - SP_W'(1);
            end
         end
         S_OUT: begin
            // Entry 0 was read in the previous cycle and stays addressed.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = final_status;
               rsp_value_in  = (final_status == ST_OK) ? rd_data : '0;
               sp_in         = '0;
               acc_in        = '0;
               in_num_in     = 1'b0;
               neg_in        = 1'b0;
               pend_in       = 1'b0;
               err_in        = ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         acc_ff       <= '0;
         in_num_ff    <= 1'b0;
         neg_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         acc_ff       <= acc_in;
         in_num_ff    <= in_num_in;
         neg_ff       <= neg_in;
         pend_ff      <= pend_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chr_ff        <= chr_in;
      eol_ff        <= eol_in;
      op_ff         <= op_in;
      ret_main_ff   <= ret_main_in;
      b_ff          <= b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;
endmodule

// File: test/rpn_scoreboard.sv
// ----------------------------------------------------------------------------
// rpn_scoreboard
// Watches the character and result channels of the postfix evaluator,
// evaluates each accepted expression in its own model and compares every
// result item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module rpn_scoreboard (
   input  logic   clock,
   input  logic   reset,
   rpn_req_if     req_ch,
   rpn_rsp_if     rsp_ch,
   output int     fail_count,
   output int     pending_count,
   output int     result_count
);
   import rpn_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
   } result_type;

   // Evaluation state of the expression being read.
   logic [WORD_W-1:0]   eval_stack [STACK_DEPTH];
   int                  depth;
   logic [WORD_W-1:0]   number;
   bit                  building;
   bit                  negative;
   bit                  minus_held;
   logic [STATUS_W-1:0] fault;
   result_type          expected_results [$];
   int                  status_seen [8];

   function automatic bit is_digit(logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void flag(logic [STATUS_W-1:0] code);
      if (fault == ST_OK) fault = code;
   endfunction

   function automatic void clear_expression();
      depth      = 0;
      number     = '0;
      building   = 0;
      negative   = 0;
      minus_held = 0;
      fault      = ST_OK;
   endfunction

   function automatic void push(logic [WORD_W-1:0] w);
      if (depth >= STACK_DEPTH) begin
         flag(ST_OVERFLOW);
      end else begin
         eval_stack[depth] = w;
         depth++;
      end
   endfunction

   function automatic void end_number();
      logic [WORD_W-1:0] w;
      if (building) begin
         w        = negative ? -number : number;
         building = 0;
         negative = 0;
         number   = '0;
         push(w);
      end
   endfunction

   function automatic void operate(logic [CHAR_W-1:0] op);
      logic [WORD_W-1:0] a, b, r, ma, mb;
      if (depth < 2) begin
         flag(ST_UNDERFLOW);
         return;
      end
      a = eval_stack[depth-2];
      b = eval_stack[depth-1];
      case (op)
         CH_PLUS: begin
            r = a + b;
         end
         CH_MINUS: begin
            r = a - b;
         end
         CH_STAR: begin
            r = a * b;
         end
         default: begin
            if (b == '0) begin
               flag(ST_DIV_ZERO);
               return;
            end
            // Divide magnitudes, then restore the sign: truncates toward zero.
            ma = a[WORD_W-1] ? -a : a;
            mb = b[WORD_W-1] ? -b : b;
            r  = ma / mb;
            if (a[WORD_W-1] ^ b[WORD_W-1]) r = -r;
         end
      endcase
      depth--;
      eval_stack[depth-1] = r;
   endfunction

   function automatic void read_character(logic [CHAR_W-1:0] c, bit last);
      bit d;
      d = is_digit(c);
      // A held minus either starts a negative number or subtracts.
      if (minus_held) begin
         minus_held = 0;
         if (d) begin
            building = 1;
            negative = 1;
            number   = '0;
         end else begin
            operate(CH_MINUS);
            if (fault != ST_OK) return;
         end
      end
      if (d) begin
         if (!building) begin
            building = 1;
            negative = 0;
            number   = '0;
         end
         number = number * 10 + WORD_W'(c - CH_ZERO);
      end else if (c == CH_MINUS) begin
         end_number();
         if (fault != ST_OK) return;
         if (last) operate(CH_MINUS);
         else minus_held = 1;
      end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH) begin
         end_number();
         if (fault != ST_OK) return;
         operate(c);
      end else if (c == CH_SPACE || c == CH_LF || c == CH_CR) begin
         end_number();
      end else begin
         flag(ST_BAD_CHAR);
         return;
      end
      if (last && fault == ST_OK) end_number();
   endfunction

   // Model each accepted character item; a line end yields one expected result.
   always @(posedge clock) begin
      result_type r;
      if (reset) begin
         clear_expression();
      end else if (req_ch.valid && req_ch.ready) begin
         if (fault == ST_OK) read_character(req_ch.character, req_ch.end_of_line);
         if (req_ch.end_of_line) begin
            r.value = '0;
            if (fault != ST_OK) begin
               r.status = fault;
            end else if (depth != 1) begin
               r.status = ST_DEPTH;
            end else begin
               r.status = ST_OK;
               r.value  = eval_stack[0];
            end
            expected_results.push_back(r);
            clear_expression();
         end
      end
   end

   // Compare each accepted result item with the oldest expectation.
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         fail_count   = 0;
         result_count = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         status_seen[rsp_ch.status]++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item value=%0d status=%0d",
                     $time, rsp_ch.value, rsp_ch.status);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_ch.value !== e.value || rsp_ch.status !== e.status) begin
               $display("%0t: expected value=%0d status=%0d, got value=%0d status=%0d",
                        $time, e.value, e.status, rsp_ch.value, rsp_ch.status);
               fail_count++;
            end
         end
      end
   end

   // Number of results still owed, refreshed between clock edges.
   always @(negedge clock) pending_count = expected_results.size();

endmodule

// File: test/postfix_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb
// Feeds directed and random postfix expressions, one character per item,
// under varying idle and stall patterns including a long result hold-off,
// and reports the verdict from the scoreboard's failure count.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;
   import rpn_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending_count, result_count;
   int   idle_pct, stall_pct;
   bit   hold_results;
   int   items_sent;

   rpn_req_if req_ch ();
   rpn_rsp_if rsp_ch ();

   postfix_expression_evaluator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   rpn_scoreboard checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // Clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Result side ready, with random stalls and an optional hold-off.
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && !hold_results && ($urandom_range(99) >= stall_pct);
   end

   // Sends one character item and waits until it is taken. The item stays
   // offered until the next call replaces it or the sender goes quiet.
   task automatic send_char(logic [7:0] c, bit last);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.character   <= c;
      req_ch.end_of_line <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Random characters: mostly digits, separators and operators.
   function automatic logic [7:0] random_char();
      case ($urandom_range(9))
         0, 1, 2, 3: return CH_ZERO + CHAR_W'($urandom_range(9));
         4, 5:       return CH_SPACE;
         6:          return $urandom_range(1) ? CH_PLUS : CH_MINUS;
         7:          return $urandom_range(1) ? CH_STAR : CH_SLASH;
         8:          return $urandom_range(1) ? CH_LF : CH_CR;
         default:    return CHAR_W'($urandom_range(255));
      endcase
   endfunction

   // A well-formed expression with random numbers and operators.
   task automatic send_valid_expression();
      int    operands;
      string s, n;
      operands = $urandom_range(1, 5);
      s = "";
      for (int i = 0; i < operands; i++) begin
         n = $sformatf("%0d", $urandom_range(1) ? $urandom_range(99) : $urandom());
         if ($urandom_range(3) == 0) n = {"-", n};
         s = {s, n, " "};
         if (i > 0) begin
            case ($urandom_range(3))
               0: s = {s, "+ "};
               1: s = {s, "- "};
               2: s = {s, "* "};
               default: s = {s, "/ "};
            endcase
         end
      end
      send_line(s.substr(0, s.len() - 2));
   endtask

   task automatic send_noise_line();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) send_char(random_char(), i == n - 1);
   endtask

   task automatic random_phase(int lines, int idle, int stall);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < lines; i++) begin
         if ($urandom_range(3) != 0) send_valid_expression();
         else send_noise_line();
      end
   endtask

   // Stimulus.
   initial begin
      string deep;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.character   = '0;
      req_ch.end_of_line = 1'b0;
      hold_results       = 0;
      idle_pct           = 0;
      stall_pct          = 0;
      items_sent         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: operators, signs, division extremes and every error.
      send_line("3 4 +");
      send_line("10 3-");
      send_line("-7 2 /");
      send_line("6 -3 *");
      send_line("-2147483648 -1 /");
      send_line("4294967297");
      send_line("5 0 /");
      send_line("+");
      send_line("1 2");
      send_line("1 a 2");
      send_char(8'hFF, 1'b1);
      send_line("\r\n 9\n");
      send_line("8 2 -");
      deep = "";
      for (int i = 0; i < STACK_DEPTH + 1; i++) deep = {deep, "1 "};
      send_line(deep);

      // Long result hold-off while characters keep arriving.
      hold_results = 1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_results = 0;
         end
         begin
            random_phase(6, 0, 0);
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      join

      random_phase(11, 0, 0);
      random_phase(11, 49, 0);
      random_phase(11, 0, 49);
      random_phase(11, 26, 26);
      while (items_sent < 1250) random_phase(2, $urandom_range(1) * 30, 0);
      req_ch.valid <= 1'b0;

      stall_pct = 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d character items, checked %0d results; status counts ok=%0d",
               items_sent, result_count, checker_i.status_seen[0]);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Timeout.
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
sv/rpn_pkg.sv
sv/rpn_if.sv
sv/rpn_ram.sv
sv/rpn_div.sv
sv/postfix_expression_evaluator.sv
test/rpn_scoreboard.sv
test/postfix_expression_evaluator_tb.sv
